@@ src/jci_pkg.sv @@
// Shared types and constants for the JPEG comment inserter.
package jci_pkg;

	localparam logic [7:0] MK_FILL = 8'hff;
	localparam logic [7:0] MK_SOI  = 8'hd8;
	localparam logic [7:0] MK_EOI  = 8'hd9;
	localparam logic [7:0] MK_COM  = 8'hfe;
	localparam logic [7:0] MK_DHT  = 8'hc4;
	localparam logic [7:0] MK_JPG  = 8'hc8;
	localparam logic [7:0] MK_DAC  = 8'hcc;

	// source of the next output byte
	typedef enum logic [2:0] {
		SEL_IN,
		SEL_FF,
		SEL_FE,
		SEL_LH,
		SEL_LL,
		SEL_COM,
		SEL_BYTE
	} out_sel_t;

	typedef struct packed {
		logic     out_load;
		out_sel_t out_sel;
		logic     out_final;
		logic     out_image_end;
		logic     wr_comment;
		logic     latch_in;
		logic     load_len_hi;
		logic     load_skip;
		logic     dec_skip;
		logic     clr_parse;
		logic     clr_count;
		logic     rd_run;
		logic     rd_next;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic in_ff;
		logic in_d8;
		logic in_insert;
		logic len_gt2;
		logic skip_done;
		logic cnt_zero;
		logic cnt_full;
		logic rd_last;
		logic last_q;
	} sts_t;

	// frame-start (SOF0-3, 5-7, 9-11, 13-15) or end of image
	function automatic logic is_insert_marker(input logic [7:0] m);
		logic sof;
		sof = (m[7:4] == 4'hc) && (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
		return sof || (m == MK_EOI);
	endfunction

endpackage

@@ src/jci_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module jci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 58,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/jci_dpath.sv @@
// Datapath: comment store, length/skip counters, input latch and output register.
module jci_dpath #(
	parameter int COMMENT_MAX = 58,
	localparam int AW = (COMMENT_MAX > 1) ? $clog2(COMMENT_MAX) : 1,
	localparam int CW = $clog2(COMMENT_MAX + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  jci_pkg::cmd_t cmd,
	output jci_pkg::sts_t sts,
	input  logic [7:0]    data_in,
	input  logic          image_last,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [7:0]    data_out,
	output logic          image_end,
	output logic          run_end
);

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] ridx_q;
	logic [AW-1:0] ridx_d;
	logic [7:0]    rdata;
	logic [7:0]    len_hi_q;
	logic [15:0]   skip_q;
	logic [15:0]   seg_len;
	logic [15:0]   com_len;
	logic [7:0]    byte_q;
	logic          last_q;
	logic          valid_q;
	logic [7:0]    out_byte;

	jci_ram #(
		.WIDTH(8),
		.DEPTH(COMMENT_MAX)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_comment),
		.waddr(cnt_q[AW-1:0]),
		.wdata(data_in),
		.raddr(ridx_d),
		.rdata(rdata)
	);

	// read address runs one ahead so rdata matches ridx_q
	always_comb begin
		if (!cmd.rd_run) begin
			ridx_d = '0;
		end else if (cmd.rd_next) begin
			ridx_d = ridx_q + AW'(1);
		end else begin
			ridx_d = ridx_q;
		end
	end

	assign seg_len = {len_hi_q, data_in};
	assign com_len = 16'(cnt_q) + 16'd2;

	always_comb begin
		case (cmd.out_sel)
			jci_pkg::SEL_IN:   out_byte = data_in;
			jci_pkg::SEL_FF:   out_byte = jci_pkg::MK_FILL;
			jci_pkg::SEL_FE:   out_byte = jci_pkg::MK_COM;
			jci_pkg::SEL_LH:   out_byte = com_len[15:8];
			jci_pkg::SEL_LL:   out_byte = com_len[7:0];
			jci_pkg::SEL_COM:  out_byte = rdata;
			jci_pkg::SEL_BYTE: out_byte = byte_q;
			default:           out_byte = byte_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ridx_q   <= '0;
			len_hi_q <= '0;
			skip_q   <= '0;
			last_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			ridx_q <= ridx_d;
			if (cmd.clr_count) begin
				cnt_q <= '0;
			end else if (cmd.wr_comment) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.clr_parse) begin
				len_hi_q <= '0;
				skip_q   <= '0;
			end else begin
				if (cmd.load_len_hi) begin
					len_hi_q <= data_in;
				end
				if (cmd.load_skip) begin
					skip_q <= seg_len - 16'd2;
				end else if (cmd.dec_skip && skip_q != 16'd0) begin
					skip_q <= skip_q - 16'd1;
				end
			end
			if (cmd.latch_in) begin
				last_q <= image_last;
			end
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			byte_q <= data_in;
		end
		if (cmd.out_load) begin
			data_out  <= out_byte;
			image_end <= cmd.out_image_end;
			run_end   <= cmd.out_final;
		end
	end

	assign res_valid = valid_q;

	always_comb begin
		sts.out_free  = !valid_q || !res_stall;
		sts.in_ff     = (data_in == jci_pkg::MK_FILL);
		sts.in_d8     = (data_in == jci_pkg::MK_SOI);
		sts.in_insert = jci_pkg::is_insert_marker(data_in);
		sts.len_gt2   = (seg_len > 16'd2);
		sts.skip_done = (skip_q <= 16'd1);
		sts.cnt_zero  = (cnt_q == '0);
		sts.cnt_full  = (cnt_q == CW'(COMMENT_MAX));
		sts.rd_last   = ((CW'(ridx_q) + CW'(1)) == cnt_q);
		sts.last_q    = last_q;
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten while stalled");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(COMMENT_MAX))
		else $error("comment count beyond store size");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_run |-> (CW'(ridx_q) < cnt_q))
		else $error("comment read past stored bytes");

endmodule

@@ src/jci_ctrl.sv @@
// Controller: marker parser state and insertion sequencer.
module jci_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic          req_type,
	input  logic          image_last,
	input  jci_pkg::sts_t sts,
	output jci_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FE,
		ST_LH,
		ST_LL,
		ST_COM,
		ST_MFF,
		ST_MB,
		ST_TAIL
	} state_t;

	typedef enum logic [2:0] {
		PH_SOI0,
		PH_SOI1,
		PH_SEEK,
		PH_LENH,
		PH_LENL,
		PH_SKIP,
		PH_PASS
	} phase_t;

	state_t st_q, st_d;
	phase_t phase_q, phase_d;
	logic   held_q, held_d;
	logic   acc;

	assign req_stall = !((st_q == ST_IDLE) && sts.out_free);
	assign acc       = req_valid && !req_stall;

	always_comb begin
		st_d    = st_q;
		phase_d = phase_q;
		held_d  = held_q;
		cmd     = '0;
		cmd.out_sel = jci_pkg::SEL_IN;

		case (st_q)
			ST_IDLE: begin
				if (acc && !req_type) begin
					cmd.wr_comment = !sts.cnt_full;
				end else if (acc) begin
					cmd.latch_in      = 1'b1;
					cmd.out_load      = 1'b1;
					cmd.out_final     = 1'b1;
					case (phase_q)
						PH_SOI0: phase_d = sts.in_ff ? PH_SOI1 : PH_PASS;
						PH_SOI1: phase_d = sts.in_d8 ? PH_SEEK : PH_PASS;
						PH_LENH: begin
							cmd.load_len_hi = 1'b1;
							phase_d = PH_LENL;
						end
						PH_LENL: begin
							if (sts.len_gt2) begin
								cmd.load_skip = 1'b1;
								phase_d = PH_SKIP;
							end else begin
								phase_d = PH_SEEK;
							end
						end
						PH_SKIP: begin
							cmd.dec_skip = 1'b1;
							if (sts.skip_done) begin
								phase_d = PH_SEEK;
							end
						end
						PH_SEEK: begin
							if (sts.in_ff && !held_q) begin
								// hold the FF; only a last byte releases it now
								held_d        = 1'b1;
								cmd.out_load  = image_last;
								cmd.out_sel   = jci_pkg::SEL_FF;
							end else if (sts.in_ff) begin
								cmd.out_sel   = jci_pkg::SEL_FF;
								cmd.out_final = !image_last;
								if (image_last) begin
									st_d = ST_TAIL;
								end
							end else if (held_q) begin
								held_d        = 1'b0;
								cmd.out_sel   = jci_pkg::SEL_FF;
								cmd.out_final = 1'b0;
								if (sts.in_insert) begin
									phase_d = PH_PASS;
									st_d = sts.cnt_zero ? ST_MB : ST_FE;
								end else begin
									phase_d = PH_LENH;
									st_d = ST_MB;
								end
							end
						end
						default: ;
					endcase
					cmd.out_image_end = image_last && cmd.out_final;
					cmd.clr_count     = image_last && cmd.out_final;
					if (image_last) begin
						phase_d       = PH_SOI0;
						held_d        = 1'b0;
						cmd.clr_parse = 1'b1;
					end
				end
			end
			ST_FE: begin
				cmd.out_sel  = jci_pkg::SEL_FE;
				cmd.out_load = sts.out_free;
				if (sts.out_free) st_d = ST_LH;
			end
			ST_LH: begin
				cmd.out_sel  = jci_pkg::SEL_LH;
				cmd.out_load = sts.out_free;
				if (sts.out_free) st_d = ST_LL;
			end
			ST_LL: begin
				cmd.out_sel  = jci_pkg::SEL_LL;
				cmd.out_load = sts.out_free;
				if (sts.out_free) st_d = ST_COM;
			end
			ST_COM: begin
				cmd.out_sel  = jci_pkg::SEL_COM;
				cmd.out_load = sts.out_free;
				cmd.rd_run   = !(sts.out_free && sts.rd_last);
				cmd.rd_next  = sts.out_free && !sts.rd_last;
				if (sts.out_free && sts.rd_last) st_d = ST_MFF;
			end
			ST_MFF: begin
				cmd.out_sel  = jci_pkg::SEL_FF;
				cmd.out_load = sts.out_free;
				if (sts.out_free) st_d = ST_MB;
			end
			ST_MB, ST_TAIL: begin
				cmd.out_sel       = (st_q == ST_MB) ? jci_pkg::SEL_BYTE : jci_pkg::SEL_FF;
				cmd.out_load      = sts.out_free;
				cmd.out_final     = 1'b1;
				cmd.out_image_end = sts.last_q;
				cmd.clr_count     = sts.out_free && sts.last_q;
				if (sts.out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= PH_SOI0;
			held_q  <= 1'b0;
		end else begin
			st_q    <= st_d;
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	a_held_seek: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> phase_q == PH_SEEK)
		else $error("FF held outside marker search");

	a_com_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_COM) |-> !sts.cnt_zero)
		else $error("comment readout with empty store");

	a_seq_after_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LL && sts.out_free) |=> st_q == ST_COM)
		else $error("length bytes not followed by comment bytes");

endmodule

@@ src/jpeg_comment_inserter.sv @@
// Top level: JPEG byte stream pass-through with COM segment insertion.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_type, data_in, image_last
//  res      out        res_valid/res_stall   data_out, image_end, run_end
//
// Plain pass-through runs one byte per cycle while res does not stall;
// comment bytes are taken at the same rate and stored until the store is full.
// At the insertion point, with a non-empty store, the sequencer emits FF FE,
// two length bytes, the N stored bytes, FF and the marker, with req_stall high
// until the marker byte is loaded into the output register.
// arst_n clears the parser and comment count at once; no clearing pass.
// A stall on res holds the output register and, through it, the input.
module jpeg_comment_inserter #(
	parameter int COMMENT_MAX = 58
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       req_type,
	input  logic [7:0] data_in,
	input  logic       image_last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] data_out,
	output logic       image_end,
	output logic       run_end
);

	jci_pkg::cmd_t cmd;
	jci_pkg::sts_t sts;

	jci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.image_last(image_last),
		.sts       (sts),
		.cmd       (cmd)
	);

	jci_dpath #(
		.COMMENT_MAX(COMMENT_MAX)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data_in   (data_in),
		.image_last(image_last),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.data_out  (data_out),
		.image_end (image_end),
		.run_end   (run_end)
	);

endmodule
